>>> src/vwt_pkg.sv
// Shared types, widths and register codes for the vertex world transform.
// No dependencies; every other file in src refers to this package by scoped names.
`default_nettype none
package vwt_pkg;

	// Field widths
	localparam int POS_W     = 32;
	localparam int DIR_W     = 16;
	localparam int DIR_FRAC  = DIR_W - 2;
	localparam int COEF_W    = 16;
	localparam int COEF_FRAC = 12;
	localparam int ROW_W     = 3 * COEF_W;
	localparam int CFG_IDX_W = 3;

	// Pipeline depth of the direction path, and of the whole block
	localparam int DIR_LAT = 57;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ROW_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_X = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Y = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT_Z = 3'd5;

	typedef logic signed [POS_W-1:0]  pos_t;
	typedef logic signed [DIR_W-1:0]  dir_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic [ROW_W-1:0]         coef_row_t;

	typedef struct packed {
		pos_t pos_in_x;
		pos_t pos_in_y;
		pos_t pos_in_z;
		dir_t norm_in_x;
		dir_t norm_in_y;
		dir_t norm_in_z;
		dir_t tan_in_x;
		dir_t tan_in_y;
		dir_t tan_in_z;
		dir_t tan_in_w;
		logic normal_present;
		logic tangent_present;
	} vwt_in_t;

	typedef struct packed {
		pos_t pos_out_x;
		pos_t pos_out_y;
		pos_t pos_out_z;
		dir_t norm_out_x;
		dir_t norm_out_y;
		dir_t norm_out_z;
		dir_t tan_out_x;
		dir_t tan_out_y;
		dir_t tan_out_z;
		dir_t tan_out_w;
	} vwt_out_t;

	// Pick coefficient k (lowest field first) out of a packed row
	function automatic coef_t coef(input coef_row_t row, input int k);
		return coef_t'(row[k*COEF_W +: COEF_W]);
	endfunction

endpackage
`default_nettype wire

>>> src/vwt_dir_path.sv
// Direction path: 3x3 linear transform of one vector, then normalization to unit length.
// Uses vwt_pkg; pipelined sqrt and divider, advances on en.
`default_nettype none
module vwt_dir_path (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire vwt_pkg::dir_t      d_x,
	input  wire vwt_pkg::dir_t      d_y,
	input  wire vwt_pkg::dir_t      d_z,
	input  wire vwt_pkg::coef_row_t row_x,
	input  wire vwt_pkg::coef_row_t row_y,
	input  wire vwt_pkg::coef_row_t row_z,
	output vwt_pkg::dir_t         o_x,
	output vwt_pkg::dir_t         o_y,
	output vwt_pkg::dir_t         o_z
);

	typedef struct packed {
		logic [2:0][29:0] nm;
		logic [2:0]       neg;
		logic             zero;
	} side_t;

	vwt_pkg::dir_t      d [3];
	vwt_pkg::coef_row_t r [3];

	logic signed [31:0] prod_s1 [3][3];
	logic signed [33:0] sum_s2  [3];
	logic [33:0]        mag_s3  [3];
	logic [2:0]         neg_s3;
	logic [33:0]        mag_s4  [3];
	logic [2:0]         neg_s4;
	logic [5:0]         msb_s4;
	logic               zero_s4;
	logic [59:0]        sqm_s6  [3];
	logic [61:0]        n_s7;
	// index is the stage number
	side_t              side_sn [5:56];
	// step g of the root lives in stage 8+g
	logic [63:0]        rt_rem  [32];
	logic [63:0]        rt_res  [32];
	logic [46:0]        num_s40 [3];
	logic [31:0]        len_s40;
	// step g of the divide lives in stage 41+g
	logic [46:0]        dv_rem  [16][3];
	logic [15:0]        dv_q    [16][3];
	logic [31:0]        dv_len  [16];
	vwt_pkg::dir_t      out_s57 [3];

	logic [33:0]        mag_or;
	logic [5:0]         msb_c;

	assign d[0] = d_x;
	assign d[1] = d_y;
	assign d[2] = d_z;
	assign r[0] = row_x;
	assign r[1] = row_y;
	assign r[2] = row_z;

	// Stages 1 to 3: products, row sums, sign and magnitude
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s1[i][k] <= vwt_pkg::coef(r[i], k) * d[k];
				end
				sum_s2[i] <= 34'(prod_s1[i][0]) + 34'(prod_s1[i][1]) + 34'(prod_s1[i][2]);
				neg_s3[i] <= sum_s2[i][33];
				mag_s3[i] <= sum_s2[i][33] ? 34'(-sum_s2[i]) : 34'(sum_s2[i]);
			end
		end
	end

	// Find the leading one of the largest magnitude
	always_comb begin
		mag_or = mag_s3[0] | mag_s3[1] | mag_s3[2];
		msb_c  = '0;
		for (int b = 0; b < 34; b++) begin
			if (mag_or[b]) msb_c = 6'(b);
		end
	end

	// Stages 4 and 5: hold the leading-one position, then scale into [2^29, 2^30);
	// carry scaled magnitudes and flags down the pipe
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4  <= mag_s3;
			neg_s4  <= neg_s3;
			msb_s4  <= msb_c;
			zero_s4 <= (mag_or == '0);
			for (int i = 0; i < 3; i++) begin
				if (msb_s4 >= 6'd30)
					side_sn[5].nm[i] <= 30'(mag_s4[i] >> (msb_s4 - 6'd29));
				else
					side_sn[5].nm[i] <= 30'(mag_s4[i] << (6'd29 - msb_s4));
			end
			side_sn[5].neg  <= neg_s4;
			side_sn[5].zero <= zero_s4;
			for (int s = 6; s <= 56; s++) begin
				side_sn[s] <= side_sn[s-1];
			end
		end
	end

	// Stages 6 and 7: squares and their sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sqm_s6[i] <= side_sn[5].nm[i] * side_sn[5].nm[i];
			end
			n_s7 <= 62'(sqm_s6[0]) + 62'(sqm_s6[1]) + 62'(sqm_s6[2]);
		end
	end

	// Stages 8 to 39: integer square root, one result bit per stage
	for (genvar g = 0; g < 32; g++) begin : g_root
		localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
		logic [63:0] rin;
		logic [63:0] sin;
		logic [63:0] t;
		if (g == 0) begin : g_first
			assign rin = {2'b00, n_s7};
			assign sin = '0;
		end else begin : g_next
			assign rin = rt_rem[g-1];
			assign sin = rt_res[g-1];
		end
		assign t = sin + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (rin >= t) begin
					rt_rem[g] <= rin - t;
					rt_res[g] <= (sin >> 1) + BIT;
				end else begin
					rt_rem[g] <= rin;
					rt_res[g] <= sin >> 1;
				end
			end
		end
	end

	// Stage 40: dividends with half the length added for rounding
	always_ff @(posedge clk) begin
		if (en) begin
			len_s40 <= rt_res[31][31:0];
			for (int i = 0; i < 3; i++) begin
				num_s40[i] <= (47'(side_sn[39].nm[i]) << vwt_pkg::DIR_FRAC)
					+ 47'(rt_res[31][31:1]);
			end
		end
	end

	// Stages 41 to 56: restoring divide, one quotient bit per stage
	for (genvar g = 0; g < 16; g++) begin : g_div
		localparam int J = 15 - g;
		logic [46:0] rin [3];
		logic [15:0] qin [3];
		logic [31:0] lin;
		logic [46:0] dsr;
		if (g == 0) begin : g_first
			assign rin = num_s40;
			assign qin = '{default: '0};
			assign lin = len_s40;
		end else begin : g_next
			assign rin = dv_rem[g-1];
			assign qin = dv_q[g-1];
			assign lin = dv_len[g-1];
		end
		assign dsr = 47'(lin) << J;
		always_ff @(posedge clk) begin
			if (en) begin
				dv_len[g] <= lin;
				for (int i = 0; i < 3; i++) begin
					if (rin[i] >= dsr) begin
						dv_rem[g][i] <= rin[i] - dsr;
						dv_q[g][i]   <= qin[i] | (16'd1 << J);
					end else begin
						dv_rem[g][i] <= rin[i];
						dv_q[g][i]   <= qin[i];
					end
				end
			end
		end
	end

	// Stage 57: clamp, restore sign, zero vector gives zero
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				if (side_sn[56].zero)
					out_s57[i] <= '0;
				else if (dv_q[15][i] > 16'h7FFF)
					out_s57[i] <= side_sn[56].neg[i] ? -16'sh7FFF : 16'sh7FFF;
				else
					out_s57[i] <= side_sn[56].neg[i] ? -$signed(dv_q[15][i])
						: $signed(dv_q[15][i]);
			end
		end
	end

	assign o_x = out_s57[0];
	assign o_y = out_s57[1];
	assign o_z = out_s57[2];

endmodule
`default_nettype wire

>>> src/vertex_world_transform_unit.sv
// Top level: configuration registers, position path and two direction paths.
// Uses vwt_pkg and vwt_dir_path.
`default_nettype none
// Takes one vertex per clock unless vtx_stall is high, and returns one transformed vertex for each.
// The depth is set by the direction normalization: a 32-stage square root and a
// 16-stage divider, both fully pipelined, so the sustained rate is one vertex per
// cycle. When a result is held by res_stall the whole pipeline freezes and
// vtx_stall rises in the same cycle; empty slots move on as long as the output
// register is empty. Registers must only be written while the pipeline is empty.
module vertex_world_transform_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         vtx_valid,
	output logic                              vtx_stall,
	input  wire vwt_pkg::vwt_in_t             vtx,
	output logic                              res_valid,
	input  wire logic                         res_stall,
	output vwt_pkg::vwt_out_t                 res,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [vwt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [vwt_pkg::ROW_W-1:0]    cfg_data
);

	localparam int LAT = vwt_pkg::DIR_LAT;

	vwt_pkg::coef_row_t row_q [3];
	vwt_pkg::pos_t      shift_q [3];
	logic [LAT:1]       vld_q;
	logic               en;

	vwt_pkg::pos_t      p [3];
	vwt_pkg::dir_t      nd [3];
	vwt_pkg::dir_t      td [3];
	vwt_pkg::dir_t      no [3];
	vwt_pkg::dir_t      to [3];

	logic signed [47:0] pprod_s1 [3][3];
	logic signed [49:0] psum_c   [3];
	logic signed [37:0] psum_s2  [3];
	logic signed [38:0] pfin_c   [3];
	vwt_pkg::pos_t      pos_sn   [3:LAT][3];
	vwt_pkg::dir_t      tanw_sn  [1:LAT];

	// Advance unless the output holds a request that is not taken
	assign en        = !(vld_q[LAT] && res_stall);
	assign vtx_stall = !en;
	assign cfg_ready = 1'b1;

	// Write configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q[0]   <= vwt_pkg::ROW_W'(48'd4096);
			row_q[1]   <= vwt_pkg::ROW_W'(48'd4096 << 16);
			row_q[2]   <= vwt_pkg::ROW_W'(48'd4096 << 32);
			shift_q[0] <= '0;
			shift_q[1] <= '0;
			shift_q[2] <= '0;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				vwt_pkg::CFG_ROW_X:   row_q[0]   <= cfg_data;
				vwt_pkg::CFG_ROW_Y:   row_q[1]   <= cfg_data;
				vwt_pkg::CFG_ROW_Z:   row_q[2]   <= cfg_data;
				vwt_pkg::CFG_SHIFT_X: shift_q[0] <= cfg_data[vwt_pkg::POS_W-1:0];
				vwt_pkg::CFG_SHIFT_Y: shift_q[1] <= cfg_data[vwt_pkg::POS_W-1:0];
				vwt_pkg::CFG_SHIFT_Z: shift_q[2] <= cfg_data[vwt_pkg::POS_W-1:0];
				default: ;
			endcase
		end
	end

	// Advance valid bits with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], vtx_valid};
		end
	end

	// Select default directions when absent
	always_comb begin
		p[0]  = vtx.pos_in_x;
		p[1]  = vtx.pos_in_y;
		p[2]  = vtx.pos_in_z;
		nd[0] = vtx.normal_present ? vtx.norm_in_x : '0;
		nd[1] = vtx.normal_present ? vtx.norm_in_y
			: vwt_pkg::DIR_W'(1) << vwt_pkg::DIR_FRAC;
		nd[2] = vtx.normal_present ? vtx.norm_in_z : '0;
		td[0] = vtx.tangent_present ? vtx.tan_in_x
			: vwt_pkg::DIR_W'(1) << vwt_pkg::DIR_FRAC;
		td[1] = vtx.tangent_present ? vtx.tan_in_y : '0;
		td[2] = vtx.tangent_present ? vtx.tan_in_z : '0;
	end

	// Round the row sums half up, then add translation; saturation follows in position stage 3
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			psum_c[i] = 50'(pprod_s1[i][0]) + 50'(pprod_s1[i][1]) + 50'(pprod_s1[i][2])
				+ 50'sd2048;
			pfin_c[i] = 39'(psum_s2[i]) + 39'(shift_q[i]);
		end
	end

	// Position stages 1 to 3, then delay positions to line up with the directions
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				for (int k = 0; k < 3; k++) begin
					pprod_s1[i][k] <= vwt_pkg::coef(row_q[i], k) * p[k];
				end
				psum_s2[i] <= psum_c[i][49:vwt_pkg::COEF_FRAC];
				if (pfin_c[i][38:vwt_pkg::POS_W-1] != {8{pfin_c[i][vwt_pkg::POS_W-1]}})
					pos_sn[3][i] <= pfin_c[i][38] ? {1'b1, {(vwt_pkg::POS_W-1){1'b0}}}
						: {1'b0, {(vwt_pkg::POS_W-1){1'b1}}};
				else
					pos_sn[3][i] <= pfin_c[i][vwt_pkg::POS_W-1:0];
			end
			for (int s = 4; s <= LAT; s++) begin
				pos_sn[s] <= pos_sn[s-1];
			end
		end
	end

	// Delay handedness to line up with the directions
	always_ff @(posedge clk) begin
		if (en) begin
			tanw_sn[1] <= vtx.tangent_present ? vtx.tan_in_w : '0;
			for (int s = 2; s <= LAT; s++) begin
				tanw_sn[s] <= tanw_sn[s-1];
			end
		end
	end

	vwt_dir_path u_norm (
		.clk   (clk),
		.en    (en),
		.d_x   (nd[0]),
		.d_y   (nd[1]),
		.d_z   (nd[2]),
		.row_x (row_q[0]),
		.row_y (row_q[1]),
		.row_z (row_q[2]),
		.o_x   (no[0]),
		.o_y   (no[1]),
		.o_z   (no[2])
	);

	vwt_dir_path u_tan (
		.clk   (clk),
		.en    (en),
		.d_x   (td[0]),
		.d_y   (td[1]),
		.d_z   (td[2]),
		.row_x (row_q[0]),
		.row_y (row_q[1]),
		.row_z (row_q[2]),
		.o_x   (to[0]),
		.o_y   (to[1]),
		.o_z   (to[2])
	);

	// Assemble the result request
	assign res_valid      = vld_q[LAT];
	assign res.pos_out_x  = pos_sn[LAT][0];
	assign res.pos_out_y  = pos_sn[LAT][1];
	assign res.pos_out_z  = pos_sn[LAT][2];
	assign res.norm_out_x = no[0];
	assign res.norm_out_y = no[1];
	assign res.norm_out_z = no[2];
	assign res.tan_out_x  = to[0];
	assign res.tan_out_y  = to[1];
	assign res.tan_out_z  = to[2];
	assign res.tan_out_w  = tanw_sn[LAT];

endmodule
`default_nettype wire

>>> bench/vertex_world_transform_checker.sv
`timescale 1ns / 1ps
// Checker for the vertex world transform: watches the vertex, result and register channels,
// predicts each transformed vertex and compares it. Depends on vwt_pkg.
module vertex_world_transform_checker (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vtx_valid,
	input  logic              vtx_stall,
	input  vwt_pkg::vwt_in_t  vtx,
	input  logic              res_valid,
	input  logic              res_stall,
	input  vwt_pkg::vwt_out_t res,
	input  logic              cfg_valid,
	input  logic              cfg_ready,
	input  logic [vwt_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [vwt_pkg::ROW_W-1:0]     cfg_data,
	output int                errors,
	output int                pending
);

	vwt_pkg::coef_row_t mat_row [3];
	logic signed [63:0] shift [3];
	vwt_pkg::vwt_out_t vertex_q [$];

	function automatic logic signed [63:0] coef_of(vwt_pkg::coef_row_t row, int k);
		logic signed [15:0] c;
		c = row[k*16 +: 16];
		return 64'(c);
	endfunction

	// Position row: exact sum, divide by 4096 rounding half up, translate, saturate
	function automatic vwt_pkg::pos_t xform_pos(vwt_pkg::coef_row_t row,
			logic signed [63:0] sh,
			logic signed [63:0] px, logic signed [63:0] py, logic signed [63:0] pz);
		logic signed [127:0] s;
		logic signed [127:0] r;
		s = 128'(coef_of(row, 0)) * 128'(px) + 128'(coef_of(row, 1)) * 128'(py)
			+ 128'(coef_of(row, 2)) * 128'(pz) + 128'sd2048;
		r = (s >>> 12) + 128'(sh);
		if (r > 128'sd2147483647) r = 128'sd2147483647;
		if (r < -128'sd2147483648) r = -128'sd2147483648;
		return vwt_pkg::pos_t'(r[31:0]);
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] n);
		logic [63:0] res_v, bit_v;
		res_v = 0;
		bit_v = 64'd1 << 62;
		while (bit_v > n) bit_v >>= 2;
		while (bit_v != 0) begin
			if (n >= res_v + bit_v) begin
				n -= res_v + bit_v;
				res_v = (res_v >> 1) + bit_v;
			end else res_v >>= 1;
			bit_v >>= 2;
		end
		return res_v;
	endfunction

	// Direction: linear part only, then scale to unit length in Q1.14
	function automatic void xform_dir(input logic signed [63:0] d [3],
			output vwt_pkg::dir_t o [3]);
		logic [63:0] mag [3];
		logic neg [3];
		logic [63:0] big, n, len, q;
		logic signed [63:0] s;
		big = 0;
		n = 0;
		for (int i = 0; i < 3; i++) begin
			s = coef_of(mat_row[i], 0) * d[0] + coef_of(mat_row[i], 1) * d[1]
				+ coef_of(mat_row[i], 2) * d[2];
			neg[i] = s < 0;
			mag[i] = neg[i] ? 64'(-s) : 64'(s);
			if (mag[i] > big) big = mag[i];
		end
		if (big == 0) begin
			for (int i = 0; i < 3; i++) o[i] = '0;
			return;
		end
		while (big >= (64'd1 << 30)) begin
			big >>= 1;
			for (int i = 0; i < 3; i++) mag[i] >>= 1;
		end
		while (big < (64'd1 << 29)) begin
			big <<= 1;
			for (int i = 0; i < 3; i++) mag[i] <<= 1;
		end
		for (int i = 0; i < 3; i++) n += mag[i] * mag[i];
		len = root_floor(n);
		for (int i = 0; i < 3; i++) begin
			q = ((mag[i] << vwt_pkg::DIR_FRAC) + len / 2) / len;
			if (q > 64'd32767) q = 64'd32767;
			o[i] = neg[i] ? vwt_pkg::dir_t'(-q) : vwt_pkg::dir_t'(q);
		end
	endfunction

	function automatic vwt_pkg::vwt_out_t predict_vertex(vwt_pkg::vwt_in_t v);
		vwt_pkg::vwt_out_t o;
		logic signed [63:0] nv [3], tv [3];
		vwt_pkg::dir_t r [3];
		o.pos_out_x = xform_pos(mat_row[0], shift[0], v.pos_in_x, v.pos_in_y, v.pos_in_z);
		o.pos_out_y = xform_pos(mat_row[1], shift[1], v.pos_in_x, v.pos_in_y, v.pos_in_z);
		o.pos_out_z = xform_pos(mat_row[2], shift[2], v.pos_in_x, v.pos_in_y, v.pos_in_z);
		if (v.normal_present) begin
			nv[0] = v.norm_in_x; nv[1] = v.norm_in_y; nv[2] = v.norm_in_z;
		end else begin
			nv[0] = 0; nv[1] = 64'sd1 << vwt_pkg::DIR_FRAC; nv[2] = 0;
		end
		if (v.tangent_present) begin
			tv[0] = v.tan_in_x; tv[1] = v.tan_in_y; tv[2] = v.tan_in_z;
		end else begin
			tv[0] = 64'sd1 << vwt_pkg::DIR_FRAC; tv[1] = 0; tv[2] = 0;
		end
		xform_dir(nv, r);
		o.norm_out_x = r[0]; o.norm_out_y = r[1]; o.norm_out_z = r[2];
		xform_dir(tv, r);
		o.tan_out_x = r[0]; o.tan_out_y = r[1]; o.tan_out_z = r[2];
		o.tan_out_w = v.tangent_present ? v.tan_in_w : vwt_pkg::dir_t'(0);
		return o;
	endfunction

	assign pending = vertex_q.size();

	// Track registers, queue predictions, compare results
	always @(posedge clk or negedge arst_n) begin
		vwt_pkg::vwt_out_t exp_v;
		if (!arst_n) begin
			mat_row[0] = 48'd4096;
			mat_row[1] = 48'd4096 << 16;
			mat_row[2] = 48'd4096 << 32;
			for (int i = 0; i < 3; i++) shift[i] = 0;
			vertex_q.delete();
			errors = 0;
		end else begin
			if (res_valid && !res_stall) begin
				if (vertex_q.size() == 0) begin
					$display("%0t: unexpected result, expected none, actual %h", $time, res);
					errors++;
				end else begin
					exp_v = vertex_q.pop_front();
					if (res !== exp_v) begin
						$display("%0t: result mismatch, expected %h, actual %h",
							$time, exp_v, res);
						errors++;
					end
				end
			end
			if (vtx_valid && !vtx_stall) vertex_q.push_back(predict_vertex(vtx));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					vwt_pkg::CFG_ROW_X:   mat_row[0] = cfg_data;
					vwt_pkg::CFG_ROW_Y:   mat_row[1] = cfg_data;
					vwt_pkg::CFG_ROW_Z:   mat_row[2] = cfg_data;
					vwt_pkg::CFG_SHIFT_X: shift[0] = 64'(signed'(cfg_data[31:0]));
					vwt_pkg::CFG_SHIFT_Y: shift[1] = 64'(signed'(cfg_data[31:0]));
					vwt_pkg::CFG_SHIFT_Z: shift[2] = 64'(signed'(cfg_data[31:0]));
					default: ;
				endcase
			end
		end
	end
endmodule

>>> bench/vertex_world_transform_unit_test.sv
`timescale 1ns / 1ps
// Stimulus and verdict for the vertex world transform unit.
// Depends on vwt_pkg, vertex_world_transform_unit and vertex_world_transform_checker.
module vertex_world_transform_unit_test;

	logic clk;
	logic arst_n;
	logic vtx_valid, vtx_stall, res_valid, res_stall, cfg_valid, cfg_ready;
	vwt_pkg::vwt_in_t vtx;
	vwt_pkg::vwt_out_t res;
	logic [vwt_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [vwt_pkg::ROW_W-1:0] cfg_data;
	int errors, pending;
	int send_idle, recv_stall;

	vertex_world_transform_unit DUT (.*);
	vertex_world_transform_checker u_checker (.*);

	initial begin
		clk = 0;
		forever #1 clk = ~clk;
	end

	// Stall the result side at the current rate
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) res_stall <= 1'b0;
		else res_stall <= ($urandom_range(99) < recv_stall);
	end

	initial begin
		#2000000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [vwt_pkg::ROW_W-1:0] coef_row(int kind);
		logic [vwt_pkg::ROW_W-1:0] r;
		for (int k = 0; k < 3; k++)
			case (kind)
				0: r[k*16 +: 16] = 16'h7fff;
				1: r[k*16 +: 16] = 16'h8000;
				default: r[k*16 +: 16] = ($urandom_range(3) == 0) ? 16'($urandom)
					: 16'($urandom_range(8192) - 4096);
			endcase
		return r;
	endfunction

	// Write one register, then leave the channel idle
	task automatic write_reg(logic [vwt_pkg::CFG_IDX_W-1:0] idx,
			logic [vwt_pkg::ROW_W-1:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// Wait for every outstanding result plus the pipeline depth
	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (vwt_pkg::DIR_LAT + 10) @(posedge clk);
	endtask

	task automatic send_vertex(vwt_pkg::vwt_in_t v);
		while ($urandom_range(99) < send_idle) begin
			vtx_valid <= 1'b0;
			@(posedge clk);
		end
		vtx_valid <= 1'b1;
		vtx <= v;
		do @(posedge clk); while (vtx_stall);
	endtask

	function automatic vwt_pkg::vwt_in_t rand_vertex();
		vwt_pkg::vwt_in_t v;
		logic [223:0] raw;
		raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
		v = raw[$bits(vwt_pkg::vwt_in_t)-1:0];
		case ($urandom_range(3))
			0: begin
				v.pos_in_x = 32'($urandom_range(2000000) - 1000000);
				v.pos_in_y = 32'($urandom_range(2000000) - 1000000);
				v.pos_in_z = 32'($urandom_range(2000000) - 1000000);
			end
			1: begin
				v.norm_in_x = 16'($urandom_range(4) - 2);
				v.tan_in_y = 16'($urandom_range(4) - 2);
			end
			default: ;
		endcase
		return v;
	endfunction

	task automatic random_config();
		write_reg(vwt_pkg::CFG_ROW_X, coef_row(2));
		write_reg(vwt_pkg::CFG_ROW_Y, coef_row(2));
		write_reg(vwt_pkg::CFG_ROW_Z, coef_row(2));
		write_reg(vwt_pkg::CFG_SHIFT_X, 48'($urandom));
		write_reg(vwt_pkg::CFG_SHIFT_Y, 48'($urandom));
		write_reg(vwt_pkg::CFG_SHIFT_Z, 48'($urandom));
	endtask

	initial begin
		vwt_pkg::vwt_in_t v;
		arst_n = 1'b0;
		vtx_valid = 1'b0;
		vtx = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		send_idle = 0;
		recv_stall = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: extremes, defaults, zero directions, under reset identity
		for (int i = 0; i < 16; i++) begin
			v = '0;
			v.normal_present = i[0];
			v.tangent_present = i[1];
			case (i >> 2)
				1: v = {{3{32'h7fffffff}}, {7{16'h7fff}}, i[1:0]};
				2: v = {{3{32'h80000000}}, {7{16'h8000}}, i[1:0]};
				3: v = {32'h12345678, 32'h80000001, 32'h00008000, 16'h4000, 16'hc000,
					16'h0001, 16'h0000, 16'h0000, 16'hffff, 16'hc000, i[1:0]};
				default: ;
			endcase
			send_vertex(v);
		end
		vtx_valid <= 1'b0;
		drain();
		write_reg(vwt_pkg::CFG_ROW_X, coef_row(0));
		write_reg(vwt_pkg::CFG_ROW_Y, coef_row(1));
		write_reg(vwt_pkg::CFG_ROW_Z, 48'h0);
		write_reg(vwt_pkg::CFG_SHIFT_X, 48'h7fffffff);
		write_reg(vwt_pkg::CFG_SHIFT_Y, 48'h80000000);
		write_reg(vwt_pkg::CFG_SHIFT_Z, 48'hffff_ffffffff);
		for (int i = 0; i < 8; i++) begin
			v = rand_vertex();
			if (i < 4) v = {{3{i[0] ? 32'h7fffffff : 32'h80000000}}, {7{16'h7fff}}, i[1:0]};
			send_vertex(v);
		end
		vtx_valid <= 1'b0;
		drain();

		// Random phases over idling profiles and settings
		for (int ph = 0; ph < 8; ph++) begin
			random_config();
			case (ph % 4)
				0: begin send_idle = 0; recv_stall = 0; end
				1: begin send_idle = 68; recv_stall = 0; end
				2: begin send_idle = 0; recv_stall = 68; end
				3: begin send_idle = 36; recv_stall = 36; end
			endcase
			for (int i = 0; i < 85; i++) send_vertex(rand_vertex());
			vtx_valid <= 1'b0;
			drain();
		end

		if (errors == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
